// ===== hw/rtl/cpq_pkg.sv =====
// Shared types, sizes and codes for the command packet queue.
package cpq_pkg;

  localparam int QUEUE_SLOTS  = 8;
  localparam int PACKET_BYTES = 32;

  localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
  localparam int COUNT_W = $clog2(QUEUE_SLOTS + 1);
  localparam int FILL_W  = $clog2(PACKET_BYTES + 1);
  localparam int ADDR_W  = $clog2(QUEUE_SLOTS * PACKET_BYTES);
  localparam int LEN_W   = 6;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] source;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] packet_length;
    logic [3:0]       packet_source;
    logic             last_of_run;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop_empty;
    logic pop_start;
    logic pop_step;
    logic pop_end;
    logic clear;
  } dp_ctrl_t;

  typedef struct packed {
    logic queue_empty;
    logic stream_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/command_packet_queue.sv =====
// Top level of the command packet queue: ring of packet slots with push, pop and clear.
// Push and clear do not hold busy; a push's result appears on the cycle after the transfer.
// Pop: the result stream starts the cycle after the transfer and gives one byte per cycle,
//   holding busy until its last byte; an empty pop gives one result.
// The single read port of the byte memory paces the stream at one byte per cycle.
// Reset (rst, synchronous): empties the queue and drops any partial packet; slot storage
//   keeps its contents. Results are strobed for one cycle, as the receiver cannot stall.
module command_packet_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cpq_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             result_valid,
  output cpq_pkg::result_t result
);

  cpq_pkg::dp_ctrl_t ctrl;
  cpq_pkg::dp_stat_t stat;

  // Sequence commands; streaming a packet out blocks new transfers.
  cpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (cmd.kind),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Hold pointers, slot tables and byte memory; drive the result strobe.
  cpq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .ctrl         (ctrl),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== hw/rtl/cpq_ctrl.sv =====
// Controller state machine: decodes commands and sequences pop streaming.
module cpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        kind,
  input  cpq_pkg::dp_stat_t stat,
  output logic              busy,
  output cpq_pkg::dp_ctrl_t ctrl
);

  localparam logic [0:0] ST_IDLE   = 1'b0;
  localparam logic [0:0] ST_STREAM = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       accept;

  assign busy   = (state == ST_STREAM);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            cpq_pkg::KIND_PUSH: ctrl.push = 1'b1;
            cpq_pkg::KIND_POP: begin
              if (stat.queue_empty) begin
                ctrl.pop_empty = 1'b1;
              end else begin
                ctrl.pop_start = 1'b1;
                state_next     = ST_STREAM;
              end
            end
            cpq_pkg::KIND_CLEAR: ctrl.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_STREAM: begin
        ctrl.pop_step = 1'b1;
        if (stat.stream_last) begin
          ctrl.pop_end = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/cpq_datapath.sv =====
// Datapath: ring pointers, slot tables, byte memory and result registers.
module cpq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  cpq_pkg::cmd_t     cmd,
  input  cpq_pkg::dp_ctrl_t ctrl,
  output cpq_pkg::dp_stat_t stat,
  output logic              result_valid,
  output cpq_pkg::result_t  result
);

  localparam int SUM_W = cpq_pkg::COUNT_W + 1;

  logic [7:0] mem [cpq_pkg::QUEUE_SLOTS * cpq_pkg::PACKET_BYTES];
  logic [cpq_pkg::FILL_W-1:0] slot_length [cpq_pkg::QUEUE_SLOTS];
  logic [3:0]                 slot_source [cpq_pkg::QUEUE_SLOTS];

  logic [cpq_pkg::SLOT_W-1:0]  head_slot;
  logic [cpq_pkg::COUNT_W-1:0] packet_count;
  logic [cpq_pkg::FILL_W-1:0]  fill_count;
  logic                        dropping;
  logic                        truncated_flag;
  logic [3:0]                  cur_source;

  logic [cpq_pkg::FILL_W-1:0]  pop_idx;
  logic [cpq_pkg::FILL_W-1:0]  pop_len;
  logic [3:0]                  pop_src;
  logic [7:0]                  rd_data;

  cpq_pkg::result_t res;
  logic             res_valid;

  // push decode
  logic [SUM_W-1:0]            tail_sum;
  logic [cpq_pkg::SLOT_W-1:0]  tail;
  logic                        starting;
  logic                        drop_now;
  logic                        store_byte;
  logic [cpq_pkg::FILL_W-1:0]  fill_new;
  logic                        trunc_new;
  logic [3:0]                  src_eff;
  logic [cpq_pkg::ADDR_W-1:0]  wr_addr;
  logic                        wr_en;

  // pop read
  logic [cpq_pkg::FILL_W-1:0]  pop_idx_inc;
  logic [cpq_pkg::FILL_W-1:0]  rd_idx;
  logic [cpq_pkg::ADDR_W-1:0]  rd_addr;
  logic                        rd_en;
  logic [cpq_pkg::SLOT_W-1:0]  head_inc;

  assign tail_sum = SUM_W'(head_slot) + SUM_W'(packet_count);
  assign tail = (tail_sum >= SUM_W'(cpq_pkg::QUEUE_SLOTS))
              ? cpq_pkg::SLOT_W'(tail_sum - SUM_W'(cpq_pkg::QUEUE_SLOTS))
              : cpq_pkg::SLOT_W'(tail_sum);

  assign starting   = (fill_count == '0) && !dropping && !truncated_flag;
  assign drop_now   = dropping ||
                      (starting && (packet_count >= cpq_pkg::COUNT_W'(cpq_pkg::QUEUE_SLOTS)));
  assign store_byte = (fill_count < cpq_pkg::FILL_W'(cpq_pkg::PACKET_BYTES));
  assign fill_new   = store_byte ? fill_count + 1'b1 : fill_count;
  assign trunc_new  = truncated_flag || !store_byte;
  assign src_eff    = (fill_count == '0) ? cmd.source : cur_source;
  assign wr_en      = ctrl.push && !drop_now && store_byte;
  assign wr_addr    = cpq_pkg::ADDR_W'(tail * cpq_pkg::PACKET_BYTES)
                    + cpq_pkg::ADDR_W'(fill_count);

  assign pop_idx_inc = pop_idx + 1'b1;
  assign stat.stream_last = (pop_idx_inc == pop_len);
  assign stat.queue_empty = (packet_count == '0);
  assign rd_idx  = ctrl.pop_start ? '0 : pop_idx_inc;
  assign rd_en   = ctrl.pop_start || (ctrl.pop_step && !stat.stream_last);
  assign rd_addr = cpq_pkg::ADDR_W'(head_slot * cpq_pkg::PACKET_BYTES)
                 + cpq_pkg::ADDR_W'(rd_idx);
  assign head_inc = (head_slot == cpq_pkg::SLOT_W'(cpq_pkg::QUEUE_SLOTS - 1))
                  ? '0 : head_slot + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.data_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // slot tables and pop capture registers
  always_ff @(posedge clk) begin
    if (ctrl.push && !drop_now && cmd.last_byte) begin
      slot_length[tail] <= fill_new;
      slot_source[tail] <= src_eff;
    end
    if (ctrl.push && !drop_now && (fill_count == '0)) begin
      cur_source <= cmd.source;
    end
    if (ctrl.pop_start) begin
      pop_len <= slot_length[head_slot];
      pop_src <= slot_source[head_slot];
      pop_idx <= '0;
    end else if (ctrl.pop_step) begin
      pop_idx <= pop_idx_inc;
    end
  end

  // pointers and push progress
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      head_slot      <= '0;
      packet_count   <= '0;
      fill_count     <= '0;
      dropping       <= 1'b0;
      truncated_flag <= 1'b0;
    end else begin
      if (ctrl.push) begin
        if (drop_now) begin
          dropping <= !cmd.last_byte;
        end else if (cmd.last_byte) begin
          packet_count   <= packet_count + 1'b1;
          fill_count     <= '0;
          truncated_flag <= 1'b0;
        end else begin
          fill_count     <= fill_new;
          truncated_flag <= trunc_new;
        end
      end
      if (ctrl.pop_end) begin
        head_slot    <= head_inc;
        packet_count <= packet_count - 1'b1;
      end
    end
  end

  // single results: push and empty pop
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= ctrl.push || ctrl.pop_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      res.out_byte    <= '0;
      res.last_of_run <= 1'b1;
      if (drop_now) begin
        res.packet_length <= '0;
        res.packet_source <= cmd.source;
        res.status        <= cpq_pkg::STAT_FULL;
      end else begin
        res.packet_length <= cpq_pkg::LEN_W'(fill_new);
        res.packet_source <= src_eff;
        res.status        <= trunc_new ? cpq_pkg::STAT_TRUNC : cpq_pkg::STAT_OK;
      end
    end else if (ctrl.pop_empty) begin
      res.out_byte      <= '0;
      res.packet_length <= '0;
      res.packet_source <= '0;
      res.last_of_run   <= 1'b1;
      res.status        <= cpq_pkg::STAT_EMPTY;
    end
  end

  always_comb begin
    if (ctrl.pop_step) begin
      result.out_byte      = rd_data;
      result.packet_length = cpq_pkg::LEN_W'(pop_len);
      result.packet_source = pop_src;
      result.last_of_run   = stat.stream_last;
      result.status        = cpq_pkg::STAT_OK;
    end else begin
      result = res;
    end
  end

  assign result_valid = ctrl.pop_step || res_valid;

endmodule

// ===== hw/rtl/cpq_checker.sv =====
// Port-level checks for the command packet queue, bound to the top level.
module cpq_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input cpq_pkg::cmd_t    cmd,
  input logic             busy,
  input logic             result_valid,
  input cpq_pkg::result_t result
);

  // A push transfer gives exactly one final result on the next cycle.
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.kind == cpq_pkg::KIND_PUSH) |=> (result_valid && result.last_of_run))
    else $error("push transfer did not produce its result");

  // A clear transfer gives no result.
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.kind == cpq_pkg::KIND_CLEAR) |=> !result_valid)
    else $error("clear produced a result");

  // A result that is not final belongs to a pop stream, which holds busy.
  a_stream_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_of_run) |-> busy)
    else $error("non-final result while not busy");

  // An empty-queue result carries no byte and no length.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == cpq_pkg::STAT_EMPTY) |->
      (result.out_byte == '0 && result.packet_length == '0 && result.last_of_run))
    else $error("empty result carries data");

endmodule

bind command_packet_queue cpq_checker u_cpq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .cmd          (cmd),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

// ===== dv/tb.sv =====
// Testbench for the command packet queue: random and directed commands, checked per result.
`timescale 1ns / 100ps

module tb;

  // Kind 3 has no meaning in the block; send it as noise that must give no result.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int ITEM_TARGET = 260;   // counted items, noise excluded
  localparam int IDLE_LIMIT  = 1000;  // cycles with no transfer and no result
  localparam int TAIL_CYCLES = 40;    // longer than the longest pop stream

  // Scoreboard: keeps its own picture of the ring and the list of results still due.
  class packet_queue_scoreboard;
    logic [7:0]                stored_bytes [cpq_pkg::QUEUE_SLOTS][cpq_pkg::PACKET_BYTES];
    logic [cpq_pkg::LEN_W-1:0] stored_len   [cpq_pkg::QUEUE_SLOTS];
    logic [3:0]                stored_src   [cpq_pkg::QUEUE_SLOTS];
    int unsigned      oldest;      // slot of the packet that pops next
    int unsigned      held;        // committed packets
    int unsigned      bytes_in;    // bytes kept so far of the packet being written
    bit               discarding;  // packet being written started on a full ring
    bit               overflowed;  // packet being written has lost bytes
    cpq_pkg::result_t due_results[$];
    int               errors;

    task report(input string msg);
      $display("%0t ERROR %s", $time, msg);
      errors++;
    endtask

    // Work out every result one accepted command causes and queue them in order.
    function void note_transfer(input cpq_pkg::cmd_t c);
      cpq_pkg::result_t r;
      int unsigned      tail;
      int               i;
      r = '0;
      case (c.kind)
        cpq_pkg::KIND_PUSH: begin
          r.last_of_run = 1'b1;
          if (bytes_in == 0 && !discarding && held >= cpq_pkg::QUEUE_SLOTS)
            discarding = 1'b1;
          if (discarding) begin
            // whole packet is thrown away; each item echoes its own source
            r.status        = cpq_pkg::STAT_FULL;
            r.packet_source = c.source;
            if (c.last_byte) begin
              discarding = 1'b0;
              overflowed = 1'b0;
              bytes_in   = 0;
            end
          end else begin
            tail = (oldest + held) % cpq_pkg::QUEUE_SLOTS;
            if (bytes_in == 0) stored_src[tail] = c.source;
            if (bytes_in < cpq_pkg::PACKET_BYTES) begin
              stored_bytes[tail][bytes_in] = c.data_byte;
              bytes_in++;
            end else begin
              overflowed = 1'b1;
            end
            r.packet_length = cpq_pkg::LEN_W'(bytes_in);
            r.packet_source = stored_src[tail];
            r.status        = overflowed ? cpq_pkg::STAT_TRUNC : cpq_pkg::STAT_OK;
            if (c.last_byte) begin
              stored_len[tail] = cpq_pkg::LEN_W'(bytes_in);
              held++;
              bytes_in   = 0;
              overflowed = 1'b0;
            end
          end
          due_results.push_back(r);
        end
        cpq_pkg::KIND_POP: begin
          if (held == 0) begin
            r.last_of_run = 1'b1;
            r.status      = cpq_pkg::STAT_EMPTY;
            due_results.push_back(r);
          end else begin
            for (i = 0; i < int'(stored_len[oldest]); i++) begin
              r.out_byte      = stored_bytes[oldest][i];
              r.packet_length = stored_len[oldest];
              r.packet_source = stored_src[oldest];
              r.last_of_run   = (i == int'(stored_len[oldest]) - 1);
              r.status        = cpq_pkg::STAT_OK;
              due_results.push_back(r);
            end
            oldest = (oldest + 1) % cpq_pkg::QUEUE_SLOTS;
            held--;
          end
        end
        cpq_pkg::KIND_CLEAR: begin
          oldest     = 0;
          held       = 0;
          bytes_in   = 0;
          discarding = 1'b0;
          overflowed = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // Compare one strobed result with the oldest one due.
    task check_result(input cpq_pkg::result_t got);
      cpq_pkg::result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result byte=%h len=%0d src=%h last=%b status=%0d",
                         got.out_byte, got.packet_length, got.packet_source,
                         got.last_of_run, got.status));
      end else begin
        want = due_results.pop_front();
        if (got.out_byte !== want.out_byte || got.packet_length !== want.packet_length ||
            got.packet_source !== want.packet_source ||
            got.last_of_run !== want.last_of_run || got.status !== want.status)
          report($sformatf({"got byte=%h len=%0d src=%h last=%b status=%0d, ",
                            "want byte=%h len=%0d src=%h last=%b status=%0d"},
                           got.out_byte, got.packet_length, got.packet_source,
                           got.last_of_run, got.status, want.out_byte,
                           want.packet_length, want.packet_source,
                           want.last_of_run, want.status));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  cpq_pkg::cmd_t    cmd;
  logic             busy;
  logic             result_valid;
  cpq_pkg::result_t result;

  packet_queue_scoreboard sb = new();
  int items_sent   = 0;
  int no_idle_left = 0;
  int idle_cycles  = 0;

  command_packet_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results cannot be held off: take every strobed one at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  // Watchdog: reset the count on any transfer or result, bail out when it runs long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly back to back or short gaps, a few long ones, and now and then a long burst
  // with no gap at all.
  function automatic int next_gap();
    int r;
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      no_idle_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly short packets; some around the size limit and a few well past it.
  function automatic int packet_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, cpq_pkg::PACKET_BYTES - 2);
    if (r < 95) return $urandom_range(cpq_pkg::PACKET_BYTES - 1, cpq_pkg::PACKET_BYTES + 2);
    return $urandom_range(cpq_pkg::PACKET_BYTES + 3, cpq_pkg::PACKET_BYTES + 8);
  endfunction

  // Present one command and hold it until the transfer; start stays high on return so
  // the next command can follow at once.
  task automatic send_cmd(input logic [1:0] kind, input logic [7:0] data,
                          input logic last, input logic [3:0] src);
    cpq_pkg::cmd_t c;
    int            gap;
    c.kind      = kind;
    c.data_byte = data;
    c.last_byte = last;
    c.source    = src;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transfer(c);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // Drop start and hold off until every result due has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  // Push one packet of random bytes; every item carries its own random source so the
  // tag is seen to come from the first byte only. Optionally break it with a clear or
  // slip a pop in between its bytes.
  task automatic push_packet(input int nbytes, input int clear_at, input int pop_at);
    int i;
    for (i = 0; i < nbytes; i++) begin
      if (i == clear_at) begin
        send_cmd(cpq_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom), 4'($urandom));
        return;
      end
      if (i == pop_at)
        send_cmd(cpq_pkg::KIND_POP, 8'($urandom), 1'($urandom), 4'($urandom));
      send_cmd(cpq_pkg::KIND_PUSH, 8'($urandom), i == nbytes - 1, 4'($urandom));
    end
  endtask

  task automatic run_random();
    int push_weight;
    int r;
    int n;
    int nbytes;
    int clear_at;
    int pop_at;
    push_weight = 50;
    // start with one overlong packet so truncation is always seen
    push_packet(cpq_pkg::PACKET_BYTES + 2, -1, -1);
    for (n = 0; items_sent < ITEM_TARGET; n++) begin
      // shift the push/pop balance now and then so the ring swings between full and empty
      if (n % 40 == 0) push_weight = $urandom_range(20, 75);
      r = $urandom_range(0, 99);
      if (r < push_weight) begin
        nbytes   = packet_size();
        clear_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, nbytes - 1) : -1;
        pop_at   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, nbytes - 1) : -1;
        push_packet(nbytes, clear_at, pop_at);
      end else if (r < 94) begin
        send_cmd(cpq_pkg::KIND_POP, 8'($urandom), 1'($urandom), 4'($urandom));
      end else if (r < 97) begin
        send_cmd(cpq_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom), 4'($urandom));
      end else if (r < 99) begin
        send_cmd(KIND_UNUSED, 8'($urandom), 1'($urandom), 4'($urandom));
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    int i;
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pop with junk in the unused fields, one-byte packet with a zero
    // byte, two-byte packet whose tag comes from its first byte, a noise kind, pops
    // down to empty, a full ring, a packet dropped on the full ring, clear, empty pop.
    send_cmd(cpq_pkg::KIND_POP, 8'hFF, 1'b1, 4'hF);
    send_cmd(cpq_pkg::KIND_PUSH, 8'h00, 1'b1, 4'h0);
    send_cmd(cpq_pkg::KIND_PUSH, 8'hFF, 1'b0, 4'hF);
    send_cmd(cpq_pkg::KIND_PUSH, 8'h5A, 1'b1, 4'h3);
    send_cmd(KIND_UNUSED, 8'hA5, 1'b1, 4'h9);
    send_cmd(cpq_pkg::KIND_POP, 8'h00, 1'b0, 4'h0);
    send_cmd(cpq_pkg::KIND_POP, 8'h00, 1'b0, 4'h0);
    send_cmd(cpq_pkg::KIND_POP, 8'h00, 1'b0, 4'h0);
    for (i = 0; i < cpq_pkg::QUEUE_SLOTS; i++) begin
      send_cmd(cpq_pkg::KIND_PUSH, 8'(i * 37 + 1), 1'b1, 4'(i));
    end
    send_cmd(cpq_pkg::KIND_PUSH, 8'h11, 1'b0, 4'h6);
    send_cmd(cpq_pkg::KIND_PUSH, 8'h22, 1'b1, 4'h9);
    send_cmd(cpq_pkg::KIND_CLEAR, 8'hFF, 1'b1, 4'hF);
    send_cmd(cpq_pkg::KIND_POP, 8'h00, 1'b0, 4'h0);
    drain_results();

    run_random();

    // Let the last stream finish, then allow time for any stray result to show.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cpq_pkg.sv
hw/rtl/cpq_ctrl.sv
hw/rtl/cpq_datapath.sv
hw/rtl/command_packet_queue.sv
hw/rtl/cpq_checker.sv
dv/tb.sv
